// File: design/seiuds_pkg.sv
// Shared types, constants and helpers for the SEI user data scanner.
package seiuds_pkg;

  localparam int MaxExpectedBytes = 16;
  localparam int UuidBytes = 16;
  localparam int ExpLimit = (MaxExpectedBytes < 16) ? MaxExpectedBytes : 16;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 64;

  localparam logic [CfgIndexWidth-1:0] CFG_UUID_HIGH       = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_UUID_LOW        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_EXPECTED_HIGH   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_EXPECTED_LOW    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_EXPECTED_LENGTH = 3'd4;

  localparam logic [7:0] EXT_BYTE        = 8'hff;
  localparam logic [7:0] START_BYTE      = 8'h01;
  localparam logic [4:0] AVC_SEI_TYPE    = 5'd6;
  localparam logic [5:0] HEVC_SEI_PRE    = 6'd39;
  localparam logic [5:0] HEVC_SEI_SUF    = 6'd40;
  localparam logic [7:0] USER_DATA_TYPE  = 8'd5;

  typedef enum logic [3:0] {
    PH_SEARCH   = 4'd0,
    PH_HDR      = 4'd1,
    PH_HDR2     = 4'd2,
    PH_TYPE     = 4'd3,
    PH_TYPE_EXT = 4'd4,
    PH_SIZE     = 4'd5,
    PH_UUID     = 4'd6,
    PH_DATA     = 4'd7,
    PH_SKIP     = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] zero_run;
  } search_t;

  // Picks byte idx of a 16-byte value held as two words, byte 0 in the top bits.
  function automatic logic [7:0] byte_of(logic [63:0] hi, logic [63:0] lo,
                                         logic [3:0] idx);
    logic [63:0] w;
    w = idx[3] ? lo : hi;
    return w[8 * (3'd7 - idx[2:0]) +: 8];
  endfunction

  // Start code detection on one byte.
  function automatic search_t search_step(logic [7:0] b, logic [1:0] zr);
    search_t s;
    s.phase = PH_SEARCH;
    s.zero_run = 2'd0;
    if (b == 8'd0) begin
      s.zero_run = (zr < 2'd2) ? zr + 2'd1 : zr;
    end else if (b == START_BYTE && zr >= 2'd2) begin
      s.phase = PH_HDR;
    end
    return s;
  endfunction

endpackage

// File: design/sei_user_data_scanner.sv
// Top level of the SEI user data scanner: byte parser and result buffer.
//
// The scanner takes one stream byte per clock while s_tready is high and updates
// its parse state in the same cycle, so bytes can be sent back to back with no
// gaps. The result (found in bit 0 of m_tdata) is produced for the byte marked
// with s_tlast and is stored as that byte is accepted. A two-entry output
// buffer decouples the sides: s_tready drops only when two results are waiting.
// Configuration registers should be written only while no stream is in flight.
module sei_user_data_scanner (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // [7:0] stream_byte
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,   // [0] found, [7:1] zero
  input  logic                                  cfg_wr_en,
  input  logic [seiuds_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [seiuds_pkg::CfgDataWidth-1:0]   cfg_data
);
  import seiuds_pkg::*;

  logic [63:0] uuid_high;
  logic [63:0] uuid_low;
  logic [63:0] expected_high;
  logic [63:0] expected_low;
  logic [4:0]  expected_length;

  phase_t      phase, phase_next;
  logic [1:0]  zero_run, zero_run_next;
  logic [4:0]  byte_counter, byte_counter_next;
  logic [15:0] size_acc, size_acc_next;
  logic        found_latch, found_latch_next;
  logic        stopped, stopped_next;

  logic        out_valid, out_found;
  logic        skid_valid, skid_found;

  logic        accept, push, pop;
  logic [7:0]  b;
  logic [16:0] sum;
  logic [15:0] sat;
  logic [15:0] acc_dec;
  logic [15:0] ep_acc;
  logic [4:0]  cnt_inc;
  logic [5:0]  hevc_type;
  search_t     srch;

  assign b         = s_tdata;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && s_tlast;
  assign pop       = m_tvalid && m_tready;
  assign s_tready  = !skid_valid;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'd0, out_found};

  assign sum       = {1'b0, size_acc} + {9'd0, b};
  assign sat       = sum[16] ? 16'hffff : sum[15:0];
  assign acc_dec   = size_acc - 16'd1;
  assign ep_acc    = (size_acc != 16'd0) ? acc_dec : 16'd0;
  assign cnt_inc   = byte_counter + 5'd1;
  assign hevc_type = b[6:1];
  assign srch      = search_step(b, zero_run);

  always_comb begin
    phase_next        = phase;
    zero_run_next     = zero_run;
    byte_counter_next = byte_counter;
    size_acc_next     = size_acc;
    found_latch_next  = found_latch;
    stopped_next      = stopped;
    if (!found_latch && !stopped) begin
      case (phase)
        PH_HDR: begin
          if (b[4:0] == AVC_SEI_TYPE) begin
            phase_next = PH_TYPE;
            zero_run_next = 2'd0;
          end else if (hevc_type == HEVC_SEI_PRE || hevc_type == HEVC_SEI_SUF) begin
            phase_next = PH_HDR2;
            zero_run_next = 2'd0;
          end else begin
            phase_next = PH_SEARCH;
            zero_run_next = (b == 8'd0) ? 2'd1 : 2'd0;
          end
        end
        PH_HDR2: begin
          if (b == 8'd0) begin
            zero_run_next = (zero_run < 2'd2) ? zero_run + 2'd1 : zero_run;
          end else begin
            zero_run_next = 2'd0;
          end
          phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          if (b == EXT_BYTE) begin
            phase_next = PH_TYPE_EXT;
            zero_run_next = 2'd0;
          end else if (b == USER_DATA_TYPE) begin
            phase_next = PH_SIZE;
            size_acc_next = 16'd0;
            zero_run_next = 2'd0;
          end else begin
            phase_next = srch.phase;
            zero_run_next = srch.zero_run;
          end
        end
        PH_TYPE_EXT: begin
          if (b == EXT_BYTE) begin
            zero_run_next = 2'd0;
          end else begin
            phase_next = srch.phase;
            zero_run_next = srch.zero_run;
          end
        end
        PH_SIZE: begin
          size_acc_next = sat;
          if (b != EXT_BYTE) begin
            if (sat < 16'(UuidBytes)) begin
              stopped_next = 1'b1;
            end else begin
              phase_next = PH_UUID;
              byte_counter_next = 5'd0;
            end
          end
        end
        PH_UUID: begin
          if (b != byte_of(uuid_high, uuid_low, byte_counter[3:0])) begin
            size_acc_next = ep_acc;
            if (ep_acc == 16'd0) begin
              phase_next = PH_SEARCH;
              zero_run_next = 2'd0;
            end else begin
              phase_next = PH_SKIP;
            end
          end else begin
            size_acc_next = acc_dec;
            byte_counter_next = cnt_inc;
            if (cnt_inc >= 5'(UuidBytes)) begin
              if (expected_length == 5'd0 || expected_length > 5'(ExpLimit) ||
                  acc_dec != {11'd0, expected_length}) begin
                stopped_next = 1'b1;
              end else begin
                phase_next = PH_DATA;
                byte_counter_next = 5'd0;
              end
            end
          end
        end
        PH_DATA: begin
          if (b != byte_of(expected_high, expected_low, byte_counter[3:0])) begin
            size_acc_next = ep_acc;
            if (ep_acc == 16'd0) begin
              phase_next = PH_SEARCH;
              zero_run_next = 2'd0;
            end else begin
              phase_next = PH_SKIP;
            end
          end else begin
            size_acc_next = acc_dec;
            byte_counter_next = cnt_inc;
            if (acc_dec == 16'd0) begin
              found_latch_next = 1'b1;
            end
          end
        end
        PH_SKIP: begin
          size_acc_next = ep_acc;
          if (ep_acc == 16'd0) begin
            phase_next = PH_SEARCH;
            zero_run_next = 2'd0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        default: begin
          phase_next = srch.phase;
          zero_run_next = srch.zero_run;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_high       <= '0;
      uuid_low        <= '0;
      expected_high   <= '0;
      expected_low    <= '0;
      expected_length <= 5'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_UUID_HIGH:       uuid_high       <= cfg_data;
        CFG_UUID_LOW:        uuid_low        <= cfg_data;
        CFG_EXPECTED_HIGH:   expected_high   <= cfg_data;
        CFG_EXPECTED_LOW:    expected_low    <= cfg_data;
        CFG_EXPECTED_LENGTH: expected_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      zero_run     <= 2'd0;
      byte_counter <= 5'd0;
      size_acc     <= 16'd0;
      found_latch  <= 1'b0;
      stopped      <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        phase        <= PH_SEARCH;
        zero_run     <= 2'd0;
        byte_counter <= 5'd0;
        size_acc     <= 16'd0;
        found_latch  <= 1'b0;
        stopped      <= 1'b0;
      end else begin
        phase        <= phase_next;
        zero_run     <= zero_run_next;
        byte_counter <= byte_counter_next;
        size_acc     <= size_acc_next;
        found_latch  <= found_latch_next;
        stopped      <= stopped_next;
      end
    end
  end

  // The output register holds the oldest result; the skid entry the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push && pop) begin
        if (skid_valid) begin
          out_found  <= skid_found;
          skid_found <= found_latch_next;
        end else begin
          out_found <= found_latch_next;
        end
      end else if (push) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
          out_found <= found_latch_next;
        end else begin
          skid_valid <= 1'b1;
          skid_found <= found_latch_next;
        end
      end else if (pop) begin
        out_valid  <= skid_valid;
        out_found  <= skid_found;
        skid_valid <= 1'b0;
      end
    end
  end

endmodule
